[hdl/lcna_pkg.sv]
package lcna_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(DEPTH);

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int AGE_W  = 4;
    localparam int SIZE_W = 7;
    localparam int CNT_W  = 4;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(9);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(MAX_COLUMNS);
    localparam logic [SIZE_W-1:0] LENGTH_RESET = SIZE_W'(MAX_ROWS);

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    localparam logic [1:0] SEL_PREV = 2'd0;
    localparam logic [1:0] SEL_MID  = 2'd1;
    localparam logic [1:0] SEL_NEXT = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LAST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0] eff_width;
        logic [SIZE_W-1:0] eff_length;
    } t_geom;

    typedef struct packed {
        logic clear;
        logic load;
        logic wr;
        logic rd_start;
        logic rd;
        logic err_res;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_query;
        logic in_range;
        logic last_step;
        logic out_free;
    } t_stat;

endpackage

[hdl/lcna_if.sv]
interface lcna_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [lcna_pkg::ROW_W-1:0]  row_index;
    logic [lcna_pkg::COL_W-1:0]  column_index;
    logic [lcna_pkg::AGE_W-1:0]  age_value;

    modport source (output valid, action, row_index, column_index, age_value, input ready);
    modport sink   (input valid, action, row_index, column_index, age_value, output ready);
endinterface

interface lcna_out_if;
    logic                        valid;
    logic                        ready;
    logic [lcna_pkg::AGE_W-1:0]  next_age;
    logic                        coordinate_error;

    modport source (output valid, next_age, coordinate_error, input ready);
    modport sink   (input valid, next_age, coordinate_error, output ready);
endinterface

[hdl/lcna_regs.sv]
module lcna_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output lcna_pkg::t_geom       o_geom
);

    logic [lcna_pkg::SIZE_W-1:0] r_width;
    logic [lcna_pkg::SIZE_W-1:0] r_length;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lcna_pkg::WIDTH_RESET;
            r_length <= lcna_pkg::LENGTH_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                lcna_pkg::REG_WIDTH:  r_width  <= pwdata[lcna_pkg::SIZE_W-1:0];
                lcna_pkg::REG_LENGTH: r_length <= pwdata[lcna_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lcna_pkg::REG_WIDTH:  prdata = 32'(r_width);
            lcna_pkg::REG_LENGTH: prdata = 32'(r_length);
            default:              prdata = '0;
        endcase
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_width == '0) begin
            o_geom.eff_width = lcna_pkg::SIZE_W'(1);
        end else if (r_width > lcna_pkg::WIDTH_RESET) begin
            o_geom.eff_width = lcna_pkg::WIDTH_RESET;
        end else begin
            o_geom.eff_width = r_width;
        end
        if (r_length == '0) begin
            o_geom.eff_length = lcna_pkg::SIZE_W'(1);
        end else if (r_length > lcna_pkg::LENGTH_RESET) begin
            o_geom.eff_length = lcna_pkg::LENGTH_RESET;
        end else begin
            o_geom.eff_length = r_length;
        end
    end

endmodule

[hdl/lcna_ctrl.sv]
module lcna_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  lcna_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output lcna_pkg::t_cmd   o_cmd
);

    lcna_pkg::t_state r_state;
    lcna_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcna_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lcna_pkg::ST_CLEAR: begin
                if (i_stat.clear_done) n_state = lcna_pkg::ST_IDLE;
            end
            lcna_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lcna_pkg::ST_EXEC;
            end
            lcna_pkg::ST_EXEC: begin
                if (!i_stat.is_query) begin
                    n_state = lcna_pkg::ST_IDLE;
                end else if (!i_stat.in_range) begin
                    n_state = lcna_pkg::ST_EMIT;
                end else begin
                    n_state = lcna_pkg::ST_READ;
                end
            end
            lcna_pkg::ST_READ: begin
                if (i_stat.last_step) n_state = lcna_pkg::ST_LAST;
            end
            lcna_pkg::ST_LAST: begin
                n_state = lcna_pkg::ST_EMIT;
            end
            lcna_pkg::ST_EMIT: begin
                if (i_stat.out_free) n_state = lcna_pkg::ST_IDLE;
            end
            default: n_state = lcna_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lcna_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            lcna_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lcna_pkg::ST_EXEC: begin
                o_cmd.wr       = !i_stat.is_query;
                o_cmd.err_res  = i_stat.is_query & !i_stat.in_range;
                o_cmd.rd_start = i_stat.is_query & i_stat.in_range;
            end
            lcna_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            lcna_pkg::ST_LAST: begin
                o_cmd.finish = 1'b1;
            end
            lcna_pkg::ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

[hdl/lcna_dp.sv]
module lcna_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lcna_pkg::t_cmd   i_cmd,
    input  lcna_pkg::t_geom  i_geom,
    input  logic                         i_action,
    input  logic [lcna_pkg::ROW_W-1:0]   i_row_index,
    input  logic [lcna_pkg::COL_W-1:0]   i_column_index,
    input  logic [lcna_pkg::AGE_W-1:0]   i_age_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [lcna_pkg::AGE_W-1:0]   o_next_age,
    output logic                         o_coordinate_error,
    output lcna_pkg::t_stat  o_stat
);

    logic [lcna_pkg::AGE_W-1:0]  r_mem [lcna_pkg::DEPTH];
    logic [lcna_pkg::AGE_W-1:0]  r_rdata;
    logic [lcna_pkg::ADDR_W-1:0] r_clr_addr;

    logic                        r_action;
    logic [lcna_pkg::ROW_W-1:0]  r_row;
    logic [lcna_pkg::COL_W-1:0]  r_col;
    logic [lcna_pkg::AGE_W-1:0]  r_age;

    logic [1:0]                  r_rsel;
    logic [1:0]                  r_csel;
    logic                        r_acc_pend;
    logic                        r_acc_center;
    logic [lcna_pkg::CNT_W-1:0]  r_count;
    logic [lcna_pkg::AGE_W-1:0]  r_cur;

    logic [lcna_pkg::AGE_W-1:0]  r_res_age;
    logic                        r_res_err;
    logic                        r_out_valid;
    logic [lcna_pkg::AGE_W-1:0]  r_out_age;
    logic                        r_out_err;

    logic                        w_in_range;
    logic [lcna_pkg::ROW_W-1:0]  w_row_prev;
    logic [lcna_pkg::ROW_W-1:0]  w_row_next;
    logic [lcna_pkg::COL_W-1:0]  w_col_prev;
    logic [lcna_pkg::COL_W-1:0]  w_col_next;
    logic [lcna_pkg::ROW_W-1:0]  w_rd_row;
    logic [lcna_pkg::COL_W-1:0]  w_rd_col;
    logic [lcna_pkg::ADDR_W-1:0] w_rd_addr;
    logic [lcna_pkg::ADDR_W-1:0] w_item_addr;
    logic [lcna_pkg::ADDR_W-1:0] w_wr_addr;
    logic [lcna_pkg::AGE_W-1:0]  w_wr_data;
    logic                        w_wr_en;
    logic                        w_center;
    logic                        w_last_step;
    logic [lcna_pkg::CNT_W-1:0]  w_final_count;
    logic                        w_lives;
    logic [lcna_pkg::AGE_W-1:0]  w_next_age;
    logic [lcna_pkg::AGE_W-1:0]  w_sat_age;

    assign w_in_range = ({1'b0, r_row} < i_geom.eff_length)
                      && ({1'b0, r_col} < i_geom.eff_width);

    // toroidal neighbors, the cell itself is known to be in range
    assign w_row_prev = (r_row == '0)
                      ? lcna_pkg::ROW_W'(i_geom.eff_length - lcna_pkg::SIZE_W'(1))
                      : r_row - lcna_pkg::ROW_W'(1);
    assign w_row_next = ({1'b0, r_row} == i_geom.eff_length - lcna_pkg::SIZE_W'(1))
                      ? '0 : r_row + lcna_pkg::ROW_W'(1);
    assign w_col_prev = (r_col == '0)
                      ? lcna_pkg::COL_W'(i_geom.eff_width - lcna_pkg::SIZE_W'(1))
                      : r_col - lcna_pkg::COL_W'(1);
    assign w_col_next = ({1'b0, r_col} == i_geom.eff_width - lcna_pkg::SIZE_W'(1))
                      ? '0 : r_col + lcna_pkg::COL_W'(1);

    always_comb begin
        case (r_rsel)
            lcna_pkg::SEL_PREV: w_rd_row = w_row_prev;
            lcna_pkg::SEL_NEXT: w_rd_row = w_row_next;
            default:            w_rd_row = r_row;
        endcase
        case (r_csel)
            lcna_pkg::SEL_PREV: w_rd_col = w_col_prev;
            lcna_pkg::SEL_NEXT: w_rd_col = w_col_next;
            default:            w_rd_col = r_col;
        endcase
    end

    assign w_rd_addr   = lcna_pkg::ADDR_W'(w_rd_row)
                       * lcna_pkg::ADDR_W'(lcna_pkg::MAX_COLUMNS)
                       + lcna_pkg::ADDR_W'(w_rd_col);
    assign w_item_addr = lcna_pkg::ADDR_W'(r_row)
                       * lcna_pkg::ADDR_W'(lcna_pkg::MAX_COLUMNS)
                       + lcna_pkg::ADDR_W'(r_col);

    assign w_center    = (r_rsel == lcna_pkg::SEL_MID) && (r_csel == lcna_pkg::SEL_MID);
    assign w_last_step = (r_rsel == lcna_pkg::SEL_NEXT) && (r_csel == lcna_pkg::SEL_NEXT);

    assign w_sat_age = (r_age > lcna_pkg::AGE_MAX) ? lcna_pkg::AGE_MAX : r_age;
    assign w_wr_en   = i_cmd.clear || (i_cmd.wr && w_in_range);
    assign w_wr_addr = i_cmd.clear ? r_clr_addr : w_item_addr;
    assign w_wr_data = i_cmd.clear ? '0 : w_sat_age;

    // grid memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (i_cmd.rd) r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + lcna_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_row    <= i_row_index;
            r_col    <= i_column_index;
            r_age    <= i_age_value;
        end
    end

    // neighbor walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsel       <= lcna_pkg::SEL_PREV;
            r_csel       <= lcna_pkg::SEL_PREV;
            r_acc_pend   <= 1'b0;
            r_acc_center <= 1'b0;
        end else begin
            r_acc_pend   <= i_cmd.rd;
            r_acc_center <= w_center;
            if (i_cmd.rd_start) begin
                r_rsel <= lcna_pkg::SEL_PREV;
                r_csel <= lcna_pkg::SEL_PREV;
            end else if (i_cmd.rd) begin
                if (r_csel == lcna_pkg::SEL_NEXT) begin
                    r_csel <= lcna_pkg::SEL_PREV;
                    r_rsel <= r_rsel + 2'd1;
                end else begin
                    r_csel <= r_csel + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_count <= '0;
        end else if (r_acc_pend) begin
            if (r_acc_center) begin
                r_cur <= r_rdata;
            end else if (r_rdata != '0) begin
                r_count <= r_count + lcna_pkg::CNT_W'(1);
            end
        end
    end

    // last beat of the walk is a corner neighbor, never the center
    assign w_final_count = r_count + lcna_pkg::CNT_W'(r_rdata != '0);

    always_comb begin
        if (r_cur != '0) begin
            w_lives = (w_final_count == lcna_pkg::CNT_W'(2))
                   || (w_final_count == lcna_pkg::CNT_W'(3));
        end else begin
            w_lives = (w_final_count == lcna_pkg::CNT_W'(3));
        end
        if (!w_lives) begin
            w_next_age = '0;
        end else if (r_cur >= lcna_pkg::AGE_MAX) begin
            w_next_age = lcna_pkg::AGE_MAX;
        end else begin
            w_next_age = r_cur + lcna_pkg::AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_res) begin
            r_res_age <= '0;
            r_res_err <= 1'b1;
        end else if (i_cmd.finish) begin
            r_res_age <= w_next_age;
            r_res_err <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_age <= r_res_age;
            r_out_err <= r_res_err;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_next_age         = r_out_age;
    assign o_coordinate_error = r_out_err;

    assign o_stat.clear_done = (r_clr_addr == lcna_pkg::ADDR_W'(lcna_pkg::DEPTH - 1));
    assign o_stat.is_query   = (r_action == lcna_pkg::ACT_QUERY);
    assign o_stat.in_range   = w_in_range;
    assign o_stat.last_step  = w_last_step;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

[hdl/life_cell_next_age.sv]
// write beat: accepted, grid updated in the next cycle if the cell is in range
// query beat: 9 grid reads through one synchronous read port; the next beat is taken
//   only once the result is in the output register; out of range queries skip the reads
// a finished result sits in an output register, so beats flow until the next query result
// reset: synchronous active low, then a clearing pass walks the addresses and zeroes every cell
//   before the first input beat is taken; register writes are taken throughout
module life_cell_next_age (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcna_in_if.sink            i_item,
    lcna_out_if.source         o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    lcna_pkg::t_geom w_geom;
    lcna_pkg::t_cmd  w_cmd;
    lcna_pkg::t_stat w_stat;

    lcna_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    lcna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_item.ready),
        .o_cmd      (w_cmd)
    );

    lcna_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_geom             (w_geom),
        .i_action           (i_item.action),
        .i_row_index        (i_item.row_index),
        .i_column_index     (i_item.column_index),
        .i_age_value        (i_item.age_value),
        .i_out_ready        (o_result.ready),
        .o_out_valid        (o_result.valid),
        .o_next_age         (o_result.next_age),
        .o_coordinate_error (o_result.coordinate_error),
        .o_stat             (w_stat)
    );

endmodule

[tb/tb_life_cell_next_age.sv]
module tb_life_cell_next_age;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic                       action;
        logic [lcna_pkg::ROW_W-1:0] row;
        logic [lcna_pkg::COL_W-1:0] col;
        logic [lcna_pkg::AGE_W-1:0] age;
    } t_cell_cmd;

    typedef struct packed {
        logic [lcna_pkg::AGE_W-1:0] next_age;
        logic                       coord_err;
    } t_next_age;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcna_in_if  item_bus ();
    lcna_out_if result_bus ();

    life_cell_next_age u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [lcna_pkg::AGE_W-1:0]  age_grid [lcna_pkg::DEPTH];
    logic [lcna_pkg::SIZE_W-1:0] width_reg;
    logic [lcna_pkg::SIZE_W-1:0] length_reg;
    t_next_age                   pending_ages [$];
    int                          mismatches;
    int                          burst_left;
    int                          stalled_cycles;
    int                          rx_cycle;
    int                          rx_hold_left;
    bit                          tx_gaps_on;
    t_rx_mode                    rx_mode;

    always #1 i_clk = ~i_clk;

    function automatic int clamp_size(logic [lcna_pkg::SIZE_W-1:0] raw, int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic int pick_index(int size);
        if (size <= 8) return $urandom_range(0, size - 1);
        // stay near the wrap so that neighbors are dense
        return (size - 3 + $urandom_range(0, 5)) % size;
    endfunction

    function automatic t_cell_cmd make_cmd(logic act, int r, int c, int a);
        t_cell_cmd cmd;
        cmd.action = act;
        cmd.row    = lcna_pkg::ROW_W'(r);
        cmd.col    = lcna_pkg::COL_W'(c);
        cmd.age    = lcna_pkg::AGE_W'(a);
        return cmd;
    endfunction

    function automatic t_cell_cmd random_cmd();
        t_cell_cmd cmd;
        int        pick;
        pick       = $urandom_range(0, 99);
        cmd.action = (pick < 40) ? lcna_pkg::ACT_WRITE : lcna_pkg::ACT_QUERY;
        cmd.row    = lcna_pkg::ROW_W'(pick_index(clamp_size(length_reg, lcna_pkg::MAX_ROWS)));
        cmd.col    = lcna_pkg::COL_W'(pick_index(clamp_size(width_reg, lcna_pkg::MAX_COLUMNS)));
        cmd.age    = ($urandom_range(0, 2) == 0) ? lcna_pkg::AGE_W'(0)
                                                 : lcna_pkg::AGE_W'($urandom_range(1, 15));
        if (pick >= 85) begin
            cmd = t_cell_cmd'(17'($urandom()));
        end
        return cmd;
    endfunction

    task automatic predict_item(input t_cell_cmd cmd);
        int                         cols;
        int                         rows;
        int                         r;
        int                         c;
        int                         live;
        int                         rr;
        int                         cc;
        logic [lcna_pkg::AGE_W-1:0] cur;
        t_next_age                  res;
        cols = clamp_size(width_reg, lcna_pkg::MAX_COLUMNS);
        rows = clamp_size(length_reg, lcna_pkg::MAX_ROWS);
        r    = int'(cmd.row);
        c    = int'(cmd.col);
        if (cmd.action == lcna_pkg::ACT_WRITE) begin
            if (r < rows && c < cols) begin
                age_grid[r * lcna_pkg::MAX_COLUMNS + c] =
                    (cmd.age > lcna_pkg::AGE_MAX) ? lcna_pkg::AGE_MAX : cmd.age;
            end
            return;
        end
        res.next_age  = '0;
        res.coord_err = 1'b1;
        if (r < rows && c < cols) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = (r + rows + dr) % rows;
                    cc = (c + cols + dc) % cols;
                    if ((dr != 0 || dc != 0)
                            && age_grid[rr * lcna_pkg::MAX_COLUMNS + cc] != '0) begin
                        live++;
                    end
                end
            end
            cur           = age_grid[r * lcna_pkg::MAX_COLUMNS + c];
            res.coord_err = 1'b0;
            if ((cur != '0 && (live == 2 || live == 3)) || (cur == '0 && live == 3)) begin
                res.next_age = (cur < lcna_pkg::AGE_MAX) ? cur + 1'b1 : lcna_pkg::AGE_MAX;
            end
        end
        pending_ages.push_back(res);
    endtask

    task automatic send_item(input t_cell_cmd cmd);
        if (tx_gaps_on && burst_left == 0) begin
            @(negedge i_clk);
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        item_bus.valid        <= 1'b1;
        item_bus.action       <= cmd.action;
        item_bus.row_index    <= cmd.row;
        item_bus.column_index <= cmd.col;
        item_bus.age_value    <= cmd.age;
        do @(posedge i_clk); while (!item_bus.ready);
        predict_item(cmd);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_item(random_cmd());
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
        while (pending_ages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size_reg(input logic idx, input logic [lcna_pkg::SIZE_W-1:0] raw);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'($urandom()), raw};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == lcna_pkg::REG_WIDTH) width_reg = raw;
        else length_reg = raw;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_grid_size(input int cols, input int rows);
        drain_results();
        write_size_reg(lcna_pkg::REG_WIDTH, lcna_pkg::SIZE_W'(cols));
        write_size_reg(lcna_pkg::REG_LENGTH, lcna_pkg::SIZE_W'(rows));
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_mode    = t_rx_mode'($urandom_range(0, 2));
    endtask

    task automatic test_directed();
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 15));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 63, 63, 15));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 0, 63, 1));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 63, 0, 5));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 0, 0, 9));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 0, 0, 8));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 1, 1, 2));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 63, 63, 0));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 42, 21, 10));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 42, 21, 6));
    endtask

    task automatic test_tiny_grids();
        // zero size acts as one, every neighbor is the cell itself
        set_grid_size(0, 0);
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 0, 0, 3));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 1, 0));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 1, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 63, 63, 9));
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 0, 5, 7));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        run_random(40);
        set_grid_size(2, 2);
        send_item(make_cmd(lcna_pkg::ACT_WRITE, 1, 1, 4));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 1, 0, 0));
        send_item(make_cmd(lcna_pkg::ACT_QUERY, 0, 0, 0));
        run_random(50);
        set_grid_size(1, 1);
        run_random(30);
        set_grid_size(2, 1);
        run_random(30);
    endtask

    task automatic test_large_sizes();
        set_grid_size(127, 127);
        run_random(40);
        set_grid_size(65, 64);
        run_random(40);
        set_grid_size(64, 3);
        run_random(40);
        set_grid_size(3, 100);
        run_random(40);
    endtask

    task automatic test_size_sweep();
        repeat (5) begin
            set_grid_size($urandom_range(3, 20), $urandom_range(3, 20));
            run_random(50);
        end
    endtask

    task automatic test_output_backpressure();
        set_grid_size(4, 4);
        tx_gaps_on   = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        run_random(40);
    endtask

    task automatic test_pause_until_drained();
        set_grid_size(5, 6);
        run_random(20);
        drain_results();
        run_random(20);
    endtask

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  result_bus.ready <= 1'b1;
                RX_RANDOM:  result_bus.ready <= ($urandom_range(0, 3) != 0);
                default:    result_bus.ready <= ((rx_cycle % 11) >= 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_next_age want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_ages.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual age %0d err %0b",
                         $time, result_bus.next_age, result_bus.coordinate_error);
                mismatches++;
            end else begin
                want = pending_ages.pop_front();
                if (result_bus.next_age !== want.next_age) begin
                    $display("%0t: next_age mismatch, expected %0d, actual %0d",
                             $time, want.next_age, result_bus.next_age);
                    mismatches++;
                end
                if (result_bus.coordinate_error !== want.coord_err) begin
                    $display("%0t: coordinate_error mismatch, expected %0b, actual %0b",
                             $time, want.coord_err, result_bus.coordinate_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_bus.valid && item_bus.ready)
                || (result_bus.valid && result_bus.ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, stalled_cycles);
                $display("tb_life_cell_next_age: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_bus.valid        = 1'b0;
        item_bus.action       = lcna_pkg::ACT_WRITE;
        item_bus.row_index    = '0;
        item_bus.column_index = '0;
        item_bus.age_value    = '0;
        result_bus.ready      = 1'b0;
        width_reg             = lcna_pkg::WIDTH_RESET;
        length_reg            = lcna_pkg::LENGTH_RESET;
        foreach (age_grid[i]) age_grid[i] = '0;
        mismatches            = 0;
        burst_left            = 0;
        stalled_cycles        = 0;
        rx_cycle              = 0;
        rx_hold_left          = 0;
        tx_gaps_on            = 1'b1;
        rx_mode               = RX_RANDOM;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_tiny_grids();
        test_large_sizes();
        test_size_sweep();
        test_output_backpressure();
        test_pause_until_drained();
        drain_results();

        if (mismatches == 0 && pending_ages.size() == 0) begin
            $display("tb_life_cell_next_age: PASS");
        end else begin
            $display("tb_life_cell_next_age: FAIL");
        end
        $finish;
    end

endmodule
